>>> hw/rtl/binned_quality_statistics_assert.svh
// Assertion macros for the binned quality statistics checker.
// Depends on nothing; the including module supplies i_clk and i_rst_n.
`ifndef BINNED_QUALITY_STATISTICS_ASSERT_SVH
`define BINNED_QUALITY_STATISTICS_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BQS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BQS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/bqs_pkg.sv
// Shared types and constants for the binned quality statistics block.
// Depends on nothing; imported by bqs_bin_store, bqs_checker and the top level.
`timescale 1ns / 1ps

package bqs_pkg;

    localparam int NUM_BINS  = 512;
    localparam int BIN_W     = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int BIN_CNT_W = $clog2(NUM_BINS + 1);

    localparam int APB_ADDR_W = 3;
    localparam logic REG_LEFT_TRIM = 1'b0;
    localparam logic REG_BIN_SIZE  = 1'b1;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic [7:0]  max_q;
        logic [7:0]  min_q;
        logic [31:0] count;
        logic [39:0] sum;
    } t_bin_stats;

    localparam t_bin_stats BIN_EMPTY = '{max_q: 8'h00, min_q: 8'hFF, count: 32'd0, sum: 40'd0};

    typedef struct packed {
        logic             en;
        logic [BIN_W-1:0] addr;
        t_bin_stats       data;
    } t_store_wr;

endpackage

>>> hw/rtl/binned_quality_statistics.sv
// Binned quality statistics, top level. Uses bqs_pkg and bqs_bin_store.
// A bin read passes the registered memory read port and the second stage to the output register.
// Throughput: one item per cycle while no result stall or clearing pass holds the input; a bin
// update is a read-modify-write of the bin memory with forwarding of the previous write.
// Reset: synchronous; afterwards a clearing pass writes every one of the NUM_BINS (512)
// bins while o_s_tready stays low. Configuration writes are taken throughout.
`timescale 1ns / 1ps

module binned_quality_statistics
    import bqs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream.
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [23:0]           i_s_tdata,  // quality[7:0], bin_select[16:8], zeros
    input  logic                  i_s_tlast,  // last_of_read
    input  logic                  i_s_tuser,  // operation
    // Result stream.
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [111:0]          o_m_tdata,  // bin_max[7:0], bin_min[15:8],
                                              // bin_count[47:16], bin_sum[87:48],
                                              // longest_read[103:88], dropped[104], zeros
    // Configuration port.
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [31:0]           i_pwdata,
    output logic [31:0]           o_prdata,
    output logic                  o_pready
);

    logic [15:0] r_left_trim;
    logic [15:0] r_bin_size;

    logic [15:0]          r_pos, n_pos;
    logic [15:0]          r_off, n_off;
    logic [BIN_CNT_W-1:0] r_cur_bin, n_cur_bin;
    logic [15:0]          r_longest, n_longest;
    logic                 r_dropped, n_dropped;

    logic             r_clearing;
    logic [BIN_W-1:0] r_clr_addr;

    logic             r_s1_valid;
    logic             r_s1_op;
    logic             r_s1_update;
    logic             r_s1_sel_ok;
    logic [7:0]       r_s1_q;
    logic [BIN_W-1:0] r_s1_addr;

    logic        r_m_valid;
    t_bin_stats  r_m_stats;
    logic [15:0] r_m_longest;
    logic        r_m_dropped;

    logic             accept;
    logic             is_add;
    logic [7:0]       in_quality;
    logic [8:0]       in_sel;
    logic             pos_counted;
    logic             bin_ok;
    logic             s1_stall;
    logic             s1_out;
    logic [BIN_W-1:0] rd_addr;
    logic [16:0]      off_inc;
    logic [16:0]      span;
    logic [40:0]      sum_wide;
    t_bin_stats       rd_stats;
    t_bin_stats       upd_stats;
    t_store_wr        store_wr;

    assign in_quality = i_s_tdata[7:0];
    assign in_sel     = i_s_tdata[16:8];
    assign is_add     = (i_s_tuser == OP_ADD);

    // Configuration registers.
    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == REG_BIN_SIZE) ? {16'd0, r_bin_size} : {16'd0, r_left_trim};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_trim <= 16'd0;
            r_bin_size  <= 16'd1;
        end else if (i_psel && i_penable && i_pwrite && o_pready) begin
            if (i_paddr[2] == REG_BIN_SIZE) begin
                r_bin_size <= i_pwdata[15:0];
            end else begin
                r_left_trim <= i_pwdata[15:0];
            end
        end
    end

    // Handshake and stage control.
    assign s1_stall   = r_s1_valid && (r_s1_op == OP_READ) && r_m_valid && !i_m_tready;
    assign s1_out     = r_s1_valid && (r_s1_op == OP_READ) && !s1_stall;
    assign o_s_tready = !r_clearing && !s1_stall;
    assign accept     = i_s_tvalid && o_s_tready;

    assign pos_counted = (r_pos >= r_left_trim);
    assign bin_ok      = (32'(r_cur_bin) < NUM_BINS);
    assign rd_addr     = is_add ? r_cur_bin[BIN_W-1:0] : BIN_W'(in_sel);

    assign off_inc = {1'b0, r_off} + 17'd1;
    assign span    = (r_bin_size == 16'd0) ? 17'h10000 : {1'b0, r_bin_size};

    // Position tracking and read-level state, updated as each added score is taken.
    always_comb begin
        n_pos     = r_pos;
        n_off     = r_off;
        n_cur_bin = r_cur_bin;
        n_longest = r_longest;
        n_dropped = r_dropped;
        if (accept && is_add) begin
            if (pos_counted && !bin_ok) begin
                n_dropped = 1'b1;
            end
            if (i_s_tlast) begin
                if ((r_pos == 16'hFFFF) || ((r_pos + 16'd1) > r_longest)) begin
                    n_longest = (r_pos == 16'hFFFF) ? 16'hFFFF : r_pos + 16'd1;
                end
                n_pos     = 16'd0;
                n_off     = 16'd0;
                n_cur_bin = '0;
            end else if (r_pos != 16'hFFFF) begin
                n_pos = r_pos + 16'd1;
                if (off_inc >= span) begin
                    n_off = 16'd0;
                    if (bin_ok) begin
                        n_cur_bin = r_cur_bin + BIN_CNT_W'(1);
                    end
                end else begin
                    n_off = off_inc[15:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= 16'd0;
            r_off     <= 16'd0;
            r_cur_bin <= '0;
            r_longest <= 16'd0;
            r_dropped <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_off     <= n_off;
            r_cur_bin <= n_cur_bin;
            r_longest <= n_longest;
            r_dropped <= n_dropped;
        end
    end

    // Clearing pass over the bin memory after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + BIN_W'(1);
            if (32'(r_clr_addr) == NUM_BINS - 1) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Second stage: bin memory data is available.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (!s1_stall) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op     <= i_s_tuser;
            r_s1_update <= is_add && pos_counted && bin_ok;
            r_s1_sel_ok <= (32'(in_sel) < NUM_BINS);
            r_s1_q      <= in_quality;
            r_s1_addr   <= rd_addr;
        end
    end

    always_comb begin
        upd_stats       = rd_stats;
        upd_stats.max_q = (r_s1_q > rd_stats.max_q) ? r_s1_q : rd_stats.max_q;
        upd_stats.min_q = (r_s1_q < rd_stats.min_q) ? r_s1_q : rd_stats.min_q;
        upd_stats.count = (&rd_stats.count) ? rd_stats.count : rd_stats.count + 32'd1;
        sum_wide        = {1'b0, rd_stats.sum} + {33'd0, r_s1_q};
        upd_stats.sum   = sum_wide[40] ? {40{1'b1}} : sum_wide[39:0];
    end

    always_comb begin
        if (r_clearing) begin
            store_wr.en   = 1'b1;
            store_wr.addr = r_clr_addr;
            store_wr.data = BIN_EMPTY;
        end else begin
            store_wr.en   = r_s1_valid && (r_s1_op == OP_ADD) && r_s1_update;
            store_wr.addr = r_s1_addr;
            store_wr.data = upd_stats;
        end
    end

    bqs_bin_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (store_wr),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_stats)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s1_out) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_out) begin
            r_m_stats   <= r_s1_sel_ok ? rd_stats : BIN_EMPTY;
            r_m_longest <= r_longest;
            r_m_dropped <= r_dropped;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {7'd0, r_m_dropped, r_m_longest, r_m_stats.sum, r_m_stats.count,
                         r_m_stats.min_q, r_m_stats.max_q};

endmodule

>>> hw/rtl/bqs_bin_store.sv
// Bin statistics memory with one write port and one registered read port.
// Forwards the most recent write to a read of the same entry. Uses bqs_pkg.
`timescale 1ns / 1ps

module bqs_bin_store
    import bqs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_store_wr        i_wr,
    input  logic             i_rd_en,
    input  logic [BIN_W-1:0] i_rd_addr,
    output t_bin_stats       o_rd_data
);

    t_bin_stats       r_mem [NUM_BINS];
    t_bin_stats       r_rd_data;
    logic [BIN_W-1:0] r_rd_addr;
    logic             r_fwd_valid;
    logic [BIN_W-1:0] r_fwd_addr;
    t_bin_stats       r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (i_wr.en) begin
            r_fwd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_fwd_addr <= i_wr.addr;
            r_fwd_data <= i_wr.data;
        end
    end

    // The latest write always matches the memory contents at its address.
    assign o_rd_data = (r_fwd_valid && (r_fwd_addr == r_rd_addr)) ? r_fwd_data : r_rd_data;

endmodule

>>> hw/rtl/bqs_checker.sv
// Port-level checker for binned_quality_statistics, bound to the top level.
// Depends on bqs_pkg and binned_quality_statistics_assert.svh.
`timescale 1ns / 1ps
`include "binned_quality_statistics_assert.svh"

module bqs_checker
    import bqs_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic                  i_s_tuser,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [111:0]          o_m_tdata
);

    // A new result only appears after a bin read transfer, through the second stage and the output register.
    `BQS_ASSERT_NOW(a_result_from_read, $rose(o_m_tvalid), $past(i_s_tvalid && o_s_tready && (i_s_tuser == OP_READ), 2), "result without a bin read transfer")

    // A stalled result holds its value.
    `BQS_ASSERT_NEXT(a_result_held, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "stalled result changed")

    // Once reported, the drop flag stays set in later results.
    `BQS_ASSERT_NEXT(a_drop_sticky, o_m_tvalid && o_m_tdata[104], !o_m_tvalid || o_m_tdata[104], "drop flag cleared")

    // The longest read length never falls between consecutive results.
    `BQS_ASSERT_NEXT(a_longest_grows, o_m_tvalid, !o_m_tvalid || (o_m_tdata[103:88] >= $past(o_m_tdata[103:88])), "longest read length decreased")

endmodule

bind binned_quality_statistics bqs_checker u_bqs_checker (.*);
